// File: rtl/core/ots_pkg.sv
`default_nettype none
package ots_pkg;

  // sequencer phases
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_PRES1   = 3'd1;
  localparam logic [2:0] PH_POLLREQ = 3'd2;
  localparam logic [2:0] PH_POLLCHK = 3'd3;
  localparam logic [2:0] PH_PRES2   = 3'd4;
  localparam logic [2:0] PH_READREQ = 3'd5;
  localparam logic [2:0] PH_COLLECT = 3'd6;

  // driver commands
  localparam logic [2:0] CMD_NONE   = 3'd0;
  localparam logic [2:0] CMD_RESET  = 3'd1;
  localparam logic [2:0] CMD_SEND   = 3'd2;
  localparam logic [2:0] CMD_RECV1  = 3'd3;
  localparam logic [2:0] CMD_RECVSP = 3'd4;

  // function bytes sent after skip-rom
  localparam logic [7:0] FN_CONVERT = 8'h44;
  localparam logic [7:0] FN_READSP  = 8'hbe;
  localparam logic [7:0] FN_NONE    = 8'h00;

  localparam logic [7:0] CRC_POLY = 8'h8c;

  localparam int unsigned ScratchBytes = 9;
  localparam logic [4:0] SCRATCH_LAST = 5'(ScratchBytes);

  localparam logic [15:0] TEMP_RESET = 16'd100;

  typedef struct packed {
    logic [2:0]  phase;
    logic [3:0]  byte_index;
    logic [7:0]  crc;
    logic [7:0]  low_byte;
    logic [7:0]  high_byte;
    logic [15:0] temperature;
  } seq_state_t;

  typedef struct packed {
    logic       bus_error;
    logic       presence_found;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  command_byte;
    logic [15:0] temperature;
    logic        temp_updated;
    logic        crc_mismatch;
  } result_t;

  // reflected crc-8, lsb first, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    logic [7:0] d;
    logic       mix;
    c = crc_in;
    d = data;
    for (int k = 0; k < 8; k++) begin
      mix = c[0] ^ d[0];
      c = {1'b0, c[7:1]};
      if (mix) begin
        c = c ^ CRC_POLY;
      end
      d = {1'b0, d[7:1]};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/ots_step.sv
`default_nettype none
module ots_step (
  input  wire ots_pkg::seq_state_t state,
  input  wire ots_pkg::item_t      item,
  output ots_pkg::seq_state_t      state_nxt,
  output ots_pkg::result_t         result
);

  ots_pkg::seq_state_t st;
  logic [4:0]          idx_plus;

  always_comb begin
    st = state;
    if (item.bus_error || (state.phase > ots_pkg::PH_COLLECT)) begin
      st.phase      = ots_pkg::PH_IDLE;
      st.byte_index = '0;
      st.crc        = '0;
    end
    idx_plus = {1'b0, st.byte_index} + 5'd1;

    state_nxt           = st;
    result.command      = ots_pkg::CMD_NONE;
    result.command_byte = ots_pkg::FN_NONE;
    result.temp_updated = 1'b0;
    result.crc_mismatch = 1'b0;

    case (st.phase)
      ots_pkg::PH_IDLE: begin
        result.command  = ots_pkg::CMD_RESET;
        state_nxt.phase = ots_pkg::PH_PRES1;
      end
      ots_pkg::PH_PRES1: begin
        if (!item.presence_found) begin
          state_nxt.phase = ots_pkg::PH_IDLE;
        end else begin
          result.command      = ots_pkg::CMD_SEND;
          result.command_byte = ots_pkg::FN_CONVERT;
          state_nxt.phase     = ots_pkg::PH_POLLREQ;
        end
      end
      ots_pkg::PH_POLLREQ: begin
        result.command  = ots_pkg::CMD_RECV1;
        state_nxt.phase = ots_pkg::PH_POLLCHK;
      end
      ots_pkg::PH_POLLCHK: begin
        if (item.data_byte == 8'd0) begin
          state_nxt.phase = ots_pkg::PH_POLLREQ;
        end else begin
          result.command  = ots_pkg::CMD_RESET;
          state_nxt.phase = ots_pkg::PH_PRES2;
        end
      end
      ots_pkg::PH_PRES2: begin
        if (!item.presence_found) begin
          state_nxt.phase = ots_pkg::PH_IDLE;
        end else begin
          result.command      = ots_pkg::CMD_SEND;
          result.command_byte = ots_pkg::FN_READSP;
          state_nxt.phase     = ots_pkg::PH_READREQ;
        end
      end
      ots_pkg::PH_READREQ: begin
        result.command       = ots_pkg::CMD_RECVSP;
        state_nxt.byte_index = '0;
        state_nxt.crc        = '0;
        state_nxt.high_byte  = '0;
        state_nxt.phase      = ots_pkg::PH_COLLECT;
      end
      default: begin
        // scratchpad collection
        if (idx_plus >= ots_pkg::SCRATCH_LAST) begin
          if (st.crc == item.data_byte) begin
            state_nxt.temperature = {st.high_byte, st.low_byte};
            result.temp_updated   = 1'b1;
            state_nxt.phase       = ots_pkg::PH_IDLE;
          end else begin
            result.crc_mismatch = 1'b1;
            result.command      = ots_pkg::CMD_RESET;
            state_nxt.phase     = ots_pkg::PH_PRES2;
          end
          state_nxt.byte_index = '0;
          state_nxt.crc        = '0;
        end else begin
          if (st.byte_index == 4'd0) begin
            state_nxt.low_byte = item.data_byte;
          end else if (st.byte_index == 4'd1) begin
            state_nxt.high_byte = item.data_byte;
          end
          state_nxt.crc        = ots_pkg::crc8_byte(st.crc, item.data_byte);
          state_nxt.byte_index = idx_plus[3:0];
        end
      end
    endcase

    result.temperature = state_nxt.temperature;
  end

endmodule
`default_nettype wire

// File: rtl/core/onewire_temperature_read_sequencer_unit.sv
`default_nettype none
// 1-wire temperature read sequencer
// in_* carries one completion word from the bus driver (error flag, presence
// flag, received byte); out_* carries the next driver command back, together
// with the last crc-checked raw temperature and update / mismatch flags.
// every accepted input word yields exactly one output word, in order.
// path: a word passes the input register, then the step logic, then the output
// register; while out_* stalls it may wait in the input register.
// throughput: one word per cycle while out_tready is high; the step logic, with
// the 8-bit crc update of a scratchpad byte, sits between input and output registers.
// in_tready stays high while the input register is empty or moving forward,
// so a new word is taken while a finished result still waits on out_*.
// when out_tready is low the output word holds, the input register fills,
// and then in_tready drops until the receiver takes the pending word.
// reset (rst_n low, synchronous): both registers empty, phase idle, crc and
// byte count cleared, temperature reads 100 until the first checked read.
// a bus error on any word forces the sequence back to a reset/presence pulse.
module onewire_temperature_read_sequencer_unit (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [15:0] in_tdata,   // bus_error, presence_found, data_byte[7:0], zero pad
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata   // command[2:0], command_byte[7:0], temperature[15:0],
                                  // temp_updated, crc_mismatch, zero pad
);

  // input register
  logic           in_valid_r;
  ots_pkg::item_t in_item_r;

  // sequencer state
  ots_pkg::seq_state_t state_r;
  ots_pkg::seq_state_t state_nxt;

  // output register
  logic             out_valid_r;
  ots_pkg::result_t out_res_r;
  ots_pkg::result_t result;

  logic advance;

  // a word moves from input to output register when the output slot frees up
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r.bus_error      <= in_tdata[0];
      in_item_r.presence_found <= in_tdata[1];
      in_item_r.data_byte      <= in_tdata[9:2];
    end
  end

  ots_step u_step (
    .state     (state_r),
    .item      (in_item_r),
    .state_nxt (state_nxt),
    .result    (result)
  );

  // sequencer state, updated once per word that moves forward
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase       <= ots_pkg::PH_IDLE;
      state_r.byte_index  <= '0;
      state_r.crc         <= '0;
      state_r.low_byte    <= '0;
      state_r.high_byte   <= '0;
      state_r.temperature <= ots_pkg::TEMP_RESET;
    end else if (advance) begin
      state_r.phase       <= state_nxt.phase;
      state_r.byte_index  <= state_nxt.byte_index;
      state_r.crc         <= state_nxt.crc;
      state_r.low_byte    <= state_nxt.low_byte;
      state_r.high_byte   <= state_nxt.high_byte;
      state_r.temperature <= state_nxt.temperature;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000,
                       out_res_r.crc_mismatch,
                       out_res_r.temp_updated,
                       out_res_r.temperature,
                       out_res_r.command_byte,
                       out_res_r.command};

endmodule
`default_nettype wire

// File: bench/onewire_temperature_read_sequencer_unit_tb.sv
`default_nettype none
module onewire_temperature_read_sequencer_unit_tb;

  // watchdog, far above the slowest run (about 1300 words, both sides idling)
  localparam int CYCLE_LIMIT  = 200000;
  // idle time after the last expected word is checked, before the summary
  localparam int DRAIN_CYCLES = 8;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;   // bus_error, presence_found, data_byte[7:0], zero pad
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // command[2:0], command_byte[7:0], temperature[15:0],
                                  // temp_updated, crc_mismatch, zero pad

  onewire_temperature_read_sequencer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // own copy of the sequencer state, advanced once per word sent
  logic [2:0]  seq_phase = ots_pkg::PH_IDLE;
  logic [3:0]  seq_index = '0;
  logic [7:0]  seq_crc   = '0;
  logic [7:0]  seq_low   = '0;
  logic [7:0]  seq_high  = '0;
  logic [15:0] seq_temp  = ots_pkg::TEMP_RESET;

  // driver commands still owed by the block, oldest first
  ots_pkg::result_t pending_commands[$];

  // scratchpad that the random driver plays back during a read
  logic [7:0] scratch_plan [ots_pkg::ScratchBytes];

  int send_idle_pct   = 0;
  int stall_pct       = 0;
  int error_count     = 0;
  int words_sent      = 0;
  int results_checked = 0;
  int temps_latched   = 0;
  int crc_failures    = 0;
  int bus_errors      = 0;
  int cycle_count     = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  // reflected crc-8, data taken lsb first
  function automatic logic [7:0] crc8_reflected(input logic [7:0] crc, input logic [7:0] data);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb  = crc[0] ^ data[i];
      crc = crc >> 1;
      if (fb) begin
        crc = crc ^ ots_pkg::CRC_POLY;
      end
    end
    return crc;
  endfunction

  // one driver completion in, next driver command out
  function automatic ots_pkg::result_t advance_sequencer(input logic err, input logic pres,
                                                         input logic [7:0] data);
    ots_pkg::result_t r;
    r = '0;
    r.command      = ots_pkg::CMD_NONE;
    r.command_byte = ots_pkg::FN_NONE;
    // a bus error (or a stray phase code) drops back to idle and idle runs at once
    if (err || seq_phase > ots_pkg::PH_COLLECT) begin
      seq_phase = ots_pkg::PH_IDLE;
      seq_index = '0;
      seq_crc   = '0;
    end
    case (seq_phase)
      ots_pkg::PH_IDLE: begin
        r.command = ots_pkg::CMD_RESET;
        seq_phase = ots_pkg::PH_PRES1;
      end
      ots_pkg::PH_PRES1: begin
        if (!pres) begin
          seq_phase = ots_pkg::PH_IDLE;
        end else begin
          r.command      = ots_pkg::CMD_SEND;
          r.command_byte = ots_pkg::FN_CONVERT;
          seq_phase      = ots_pkg::PH_POLLREQ;
        end
      end
      ots_pkg::PH_POLLREQ: begin
        r.command = ots_pkg::CMD_RECV1;
        seq_phase = ots_pkg::PH_POLLCHK;
      end
      ots_pkg::PH_POLLCHK: begin
        // conversion still running while the poll byte reads zero
        if (data == 8'h00) begin
          seq_phase = ots_pkg::PH_POLLREQ;
        end else begin
          r.command = ots_pkg::CMD_RESET;
          seq_phase = ots_pkg::PH_PRES2;
        end
      end
      ots_pkg::PH_PRES2: begin
        if (!pres) begin
          seq_phase = ots_pkg::PH_IDLE;
        end else begin
          r.command      = ots_pkg::CMD_SEND;
          r.command_byte = ots_pkg::FN_READSP;
          seq_phase      = ots_pkg::PH_READREQ;
        end
      end
      ots_pkg::PH_READREQ: begin
        r.command = ots_pkg::CMD_RECVSP;
        seq_index = '0;
        seq_crc   = '0;
        seq_high  = '0;
        seq_phase = ots_pkg::PH_COLLECT;
      end
      default: begin
        if (int'(seq_index) + 1 >= int'(ots_pkg::ScratchBytes)) begin
          // last scratchpad byte carries the crc of the ones before it
          if (seq_crc == data) begin
            seq_temp       = {seq_high, seq_low};
            r.temp_updated = 1'b1;
            seq_phase      = ots_pkg::PH_IDLE;
          end else begin
            r.crc_mismatch = 1'b1;
            r.command      = ots_pkg::CMD_RESET;
            seq_phase      = ots_pkg::PH_PRES2;
          end
          seq_index = '0;
          seq_crc   = '0;
        end else begin
          if (seq_index == 4'd0) begin
            seq_low = data;
          end else if (seq_index == 4'd1) begin
            seq_high = data;
          end
          seq_crc   = crc8_reflected(seq_crc, data);
          seq_index = seq_index + 4'd1;
        end
      end
    endcase
    r.temperature = seq_temp;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("mismatch on word %0d: %s got %0h expected %0h",
             results_checked, what, got, want);
  endtask

  // offers one completion word, with a random gap first, and waits for the handshake
  task automatic send_word(input logic err, input logic pres, input logic [7:0] data);
    ots_pkg::result_t want;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    want = advance_sequencer(err, pres, data);
    pending_commands.push_back(want);
    if (want.temp_updated) begin
      temps_latched++;
    end
    if (want.crc_mismatch) begin
      crc_failures++;
    end
    if (err) begin
      bus_errors++;
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, data, pres, err};
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    words_sent++;
  endtask

  // plays back one full scratchpad with presence held high
  task automatic send_scratchpad(input logic [15:0] temp, input logic good);
    logic [7:0] crc_run;
    logic [7:0] b;
    crc_run = 8'h00;
    for (int i = 0; i < int'(ots_pkg::ScratchBytes) - 1; i++) begin
      b = (i == 0) ? temp[7:0] : (i == 1) ? temp[15:8] : 8'($urandom_range(0, 255));
      crc_run = crc8_reflected(crc_run, b);
      send_word(1'b0, 1'b1, b);
    end
    send_word(1'b0, 1'b1, good ? crc_run : ~crc_run);
  endtask

  // a driver that mostly behaves: answers follow the phase the block is in,
  // with rare bus errors, missing presence, busy polls, bad crc and pure noise
  task automatic send_read_word();
    int          roll;
    logic        err;
    logic        pres;
    logic [7:0]  data;
    logic [15:0] temp_pick;
    logic [7:0]  crc_run;
    roll = $urandom_range(0, 99);
    err  = (roll < 3);
    pres = ($urandom_range(0, 99) < 90);
    data = 8'($urandom_range(0, 255));
    case (seq_phase)
      ots_pkg::PH_POLLCHK: begin
        data = ($urandom_range(0, 99) < 60) ? 8'h00 : 8'($urandom_range(1, 255));
      end
      ots_pkg::PH_READREQ: begin
        // new scratchpad for the read that starts with this word
        case ($urandom_range(0, 5))
          0:       temp_pick = 16'h8000;
          1:       temp_pick = 16'h7fff;
          2:       temp_pick = 16'hffff;
          3:       temp_pick = 16'h0000;
          default: temp_pick = 16'($urandom_range(0, 65535));
        endcase
        crc_run = 8'h00;
        for (int i = 0; i < int'(ots_pkg::ScratchBytes) - 1; i++) begin
          scratch_plan[i] = (i == 0) ? temp_pick[7:0] :
                            (i == 1) ? temp_pick[15:8] : 8'($urandom_range(0, 255));
          crc_run = crc8_reflected(crc_run, scratch_plan[i]);
        end
        scratch_plan[ots_pkg::ScratchBytes - 1] = crc_run;
        if ($urandom_range(0, 3) == 0) begin
          scratch_plan[ots_pkg::ScratchBytes - 1] = crc_run ^ 8'($urandom_range(1, 255));
        end
      end
      ots_pkg::PH_COLLECT: begin
        data = scratch_plan[seq_index];
      end
      default: ;
    endcase
    // noise words: anything the fields allow
    if (roll >= 92) begin
      err  = ($urandom_range(0, 3) == 0);
      pres = 1'($urandom_range(0, 1));
      data = 8'($urandom_range(0, 255));
    end
    send_word(err, pres, data);
  endtask

  task automatic run_random_reads(input int idle_pct, input int stall_level, input int n);
    send_idle_pct = idle_pct;
    stall_pct     = stall_level;
    repeat (n) begin
      send_read_word();
    end
  endtask

  // walks one read through every phase: error in idle, missing presence,
  // busy poll, bad crc and reread, then a good read of the most negative value
  task automatic test_directed_read();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_word(1'b1, 1'b1, 8'hff);  // bus error in idle still starts a reset pulse
    send_word(1'b0, 1'b0, 8'h00);  // no presence after the first reset
    send_word(1'b0, 1'b1, 8'h00);  // reset again
    send_word(1'b0, 1'b1, 8'h00);  // presence seen, skip-rom plus convert
    send_word(1'b0, 1'b0, 8'hff);  // first poll request
    send_word(1'b0, 1'b1, 8'h00);  // poll byte zero, conversion busy
    send_word(1'b0, 1'b0, 8'h00);  // poll again
    send_word(1'b0, 1'b0, 8'h80);  // conversion done, second reset
    send_word(1'b0, 1'b1, 8'h00);  // skip-rom plus read scratchpad
    send_word(1'b0, 1'b1, 8'h00);  // scratchpad receive
    send_scratchpad(16'h7fff, 1'b0);  // crc fails, back to the second reset
    send_word(1'b0, 1'b1, 8'h00);
    send_word(1'b0, 1'b1, 8'h00);
    send_scratchpad(16'h8000, 1'b1);  // crc matches, temperature latched
  endtask

  task automatic test_reads_back_to_back();
    run_random_reads(0, 0, 310);
  endtask

  task automatic test_reads_sender_idle();
    run_random_reads(58, 0, 310);
  endtask

  task automatic test_reads_receiver_stall();
    run_random_reads(0, 58, 310);
  endtask

  task automatic test_reads_both_idle();
    run_random_reads(34, 34, 310);
  endtask

  // receiver: random stalls at the rate set by the current test
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // each word taken from out_* is checked against the oldest expectation
  always @(posedge clk) begin
    ots_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_commands.size() == 0) begin
        report_mismatch("word with nothing expected", out_tdata, 32'h0);
      end else begin
        want = pending_commands.pop_front();
        results_checked++;
        if (out_tdata[2:0] != want.command) begin
          report_mismatch("command", 32'(out_tdata[2:0]), 32'(want.command));
        end
        if (out_tdata[10:3] != want.command_byte) begin
          report_mismatch("command_byte", 32'(out_tdata[10:3]), 32'(want.command_byte));
        end
        if (out_tdata[26:11] != want.temperature) begin
          report_mismatch("temperature", 32'(out_tdata[26:11]), 32'(want.temperature));
        end
        if (out_tdata[27] != want.temp_updated) begin
          report_mismatch("temp_updated", 32'(out_tdata[27]), 32'(want.temp_updated));
        end
        if (out_tdata[28] != want.crc_mismatch) begin
          report_mismatch("crc_mismatch", 32'(out_tdata[28]), 32'(want.crc_mismatch));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still owed",
               cycle_count, pending_commands.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_read();
    test_reads_back_to_back();
    test_reads_sender_idle();
    test_reads_receiver_stall();
    test_reads_both_idle();
    in_tvalid <= 1'b0;
    while (pending_commands.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d driver completions (%0d with bus error), checked %0d commands",
             words_sent, bus_errors, results_checked);
    $display("scratchpad reads: %0d temperatures latched, %0d crc failures, %0d mismatches",
             temps_latched, crc_failures, error_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
rtl/core/ots_pkg.sv
rtl/core/ots_step.sv
rtl/core/onewire_temperature_read_sequencer_unit.sv
bench/onewire_temperature_read_sequencer_unit_tb.sv
